// ===== rtl/edd_pkg.sv =====
// shared types, constants and error share function for the error diffusion dither unit
package edd_pkg;

    // diffused error value held in the line buffer and carry registers
    typedef logic signed [7:0] err_t;

    // error before splitting into shares, -127..127
    typedef logic signed [8:0] qerr_t;

    // configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // configuration field widths and reset values
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

    // frame height limit and row counter width
    localparam int MAX_HEIGHT = 4096;
    localparam int ROW_W      = 12;

    // luma weights in 1/256 units
    localparam logic [7:0] GRAY_R = 8'd77;
    localparam logic [7:0] GRAY_G = 8'd151;
    localparam logic [7:0] GRAY_B = 8'd28;

    // quantizer levels
    localparam logic [7:0] THRESHOLD = 8'd128;
    localparam logic [7:0] FULL      = 8'd255;

    // diffusion weights in 1/16 units
    localparam logic [2:0] W_RIGHT       = 3'd7;
    localparam logic [2:0] W_BELOW_LEFT  = 3'd3;
    localparam logic [2:0] W_BELOW       = 3'd5;
    localparam logic [2:0] W_BELOW_RIGHT = 3'd1;

    // (e * weight) / 16, truncated toward zero
    function automatic err_t share(input qerr_t e, input logic [2:0] weight);
        logic [7:0]  mag;
        logic [10:0] prod;
        logic [6:0]  q;
        mag  = e[8] ? (~e[7:0] + 8'd1) : e[7:0];
        prod = {3'b000, mag} * {8'b0000_0000, weight};
        q    = prod[10:4];
        share = e[8] ? err_t'(~{1'b0, q} + 8'd1) : err_t'({1'b0, q});
    endfunction

endpackage

// ===== rtl/error_diffusion_dither_unit.sv =====
// floyd-steinberg error diffusion dither over a raster-order rgb pixel stream
// an accepted item moves from the diffusion stage registers into the output registers, which drive m_tvalid
// throughput: one item per clock while m_tready does not stall the output, set by the line buffer
//   read-modify-write and the registered right-neighbor carry loop in the diffusion stage
// reset: counters and carries cleared, width 640 and height 480; no clearing pass,
//   the first line of each frame ignores the line buffer contents
module error_diffusion_dither_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [edd_pkg::CFG_DATA_W-1:0] cfg_data,
    // pixel input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    // dithered output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // white [0], zero fill [7:1]
    output logic        m_tlast    // frame_end
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // configuration registers
    logic [edd_pkg::WIDTH_REG_W-1:0]  image_width_reg;
    logic [edd_pkg::HEIGHT_REG_W-1:0] image_height_reg;

    // position counters
    logic [COL_W-1:0]         col_reg;
    logic [edd_pkg::ROW_W-1:0] row_reg;
    logic [COL_W-1:0]         col_last;
    logic [edd_pkg::ROW_W-1:0] row_last;

    // diffusion stage registers
    logic                 s1_valid_reg;
    logic [7:0]           s1_gray_reg;
    logic [COL_W-1:0]     s1_col_reg;
    logic                 s1_first_row_reg;
    logic                 s1_last_col_reg;
    logic                 s1_last_row_reg;
    logic                 s1_fwd_hit_reg;
    edd_pkg::err_t        s1_fwd_data_reg;
    edd_pkg::err_t        mem_q_reg;
    edd_pkg::err_t        rc_reg;
    edd_pkg::err_t        bl_reg;
    edd_pkg::err_t        hold_reg;

    // output registers
    logic                 out_valid_reg;
    logic                 white_reg;
    logic                 frame_end_reg;

    // line buffer
    edd_pkg::err_t        line_mem [MAX_WIDTH];

    logic                 s_accept;
    logic                 s1_adv;
    logic [15:0]          gray_sum;
    logic                 wr_en;
    logic [COL_W-1:0]     wr_addr;
    edd_pkg::err_t        wr_data;
    edd_pkg::err_t        e_sel;
    logic signed [9:0]    val_sum;
    logic [7:0]           pix_val;
    logic                 white;
    edd_pkg::qerr_t       qerr;
    edd_pkg::err_t        s_right;
    edd_pkg::err_t        s_below_left;
    edd_pkg::err_t        s_below;
    edd_pkg::err_t        s_below_right;
    edd_pkg::err_t        rc_next;
    edd_pkg::err_t        bl_next;
    edd_pkg::err_t        hold_next;

    // clamped last column and last row
    always_comb
    begin
        if (image_width_reg == '0)
            col_last = '0;
        else if (int'(image_width_reg) > MAX_WIDTH)
            col_last = COL_W'(MAX_WIDTH - 1);
        else
            col_last = COL_W'(image_width_reg - 11'd1);
        if (image_height_reg == '0)
            row_last = '0;
        else if (int'(image_height_reg) > edd_pkg::MAX_HEIGHT)
            row_last = edd_pkg::ROW_W'(edd_pkg::MAX_HEIGHT - 1);
        else
            row_last = edd_pkg::ROW_W'(image_height_reg - 13'd1);
    end

    // handshake
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_accept = s_tvalid && s_tready;

    // luma from the incoming pixel
    assign gray_sum = ({8'd0, edd_pkg::GRAY_R} * {8'd0, s_tdata[7:0]})
                    + ({8'd0, edd_pkg::GRAY_G} * {8'd0, s_tdata[15:8]})
                    + ({8'd0, edd_pkg::GRAY_B} * {8'd0, s_tdata[23:16]});

    // pending error for this pixel: none on the first line, the held partial
    // for one-pixel lines, else the line buffer with write forwarding
    always_comb
    begin
        if (s1_first_row_reg)
            e_sel = '0;
        else if (col_last == '0)
            e_sel = hold_reg;
        else if (s1_fwd_hit_reg)
            e_sel = s1_fwd_data_reg;
        else
            e_sel = mem_q_reg;
    end

    // add, clamp and quantize
    always_comb
    begin
        val_sum = $signed({2'b00, s1_gray_reg}) + 10'(e_sel) + 10'(rc_reg);
        if (val_sum[9])
            pix_val = '0;
        else if (val_sum > 10'sd255)
            pix_val = edd_pkg::FULL;
        else
            pix_val = val_sum[7:0];
        white = (pix_val >= edd_pkg::THRESHOLD);
        if (white)
            qerr = $signed({1'b0, pix_val} - {1'b0, edd_pkg::FULL});
        else
            qerr = $signed({1'b0, pix_val});
    end

    // error shares
    assign s_right       = edd_pkg::share(qerr, edd_pkg::W_RIGHT);
    assign s_below_left  = edd_pkg::share(qerr, edd_pkg::W_BELOW_LEFT);
    assign s_below       = edd_pkg::share(qerr, edd_pkg::W_BELOW);
    assign s_below_right = edd_pkg::share(qerr, edd_pkg::W_BELOW_RIGHT);

    assign rc_next   = s1_last_col_reg ? '0 : s_right;
    assign bl_next   = s1_last_col_reg ? '0 : s_below_right;
    assign hold_next = bl_reg + s_below;

    // line buffer write: finished entry left of this pixel, or the held
    // last-column entry of the previous line at the start of a line
    always_comb
    begin
        if (s1_col_reg == '0)
        begin
            wr_en   = s1_adv && !s1_first_row_reg;
            wr_addr = col_last;
            wr_data = hold_reg;
        end
        else
        begin
            wr_en   = s1_adv && !s1_last_row_reg;
            wr_addr = s1_col_reg - 1'b1;
            wr_data = hold_reg + s_below_left;
        end
    end

    // line buffer memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[wr_addr] <= wr_data;
        if (s_accept)
            mem_q_reg <= line_mem[col_reg];
    end

    // diffusion stage payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_gray_reg      <= gray_sum[15:8];
            s1_col_reg       <= col_reg;
            s1_first_row_reg <= (row_reg == '0);
            s1_last_col_reg  <= (col_reg == col_last);
            s1_last_row_reg  <= (row_reg == row_last);
            s1_fwd_hit_reg   <= wr_en && (wr_addr == col_reg);
            s1_fwd_data_reg  <= wr_data;
        end
        if (s1_adv)
        begin
            hold_reg      <= hold_next;
            white_reg     <= white;
            frame_end_reg <= s1_last_col_reg && s1_last_row_reg;
        end
    end

    // control state, counters and carries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= edd_pkg::WIDTH_RESET;
            image_height_reg <= edd_pkg::HEIGHT_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            rc_reg           <= '0;
            bl_reg           <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    edd_pkg::REG_IMAGE_WIDTH:
                        image_width_reg <= cfg_data[edd_pkg::WIDTH_REG_W-1:0];
                    edd_pkg::REG_IMAGE_HEIGHT:
                        image_height_reg <= cfg_data;
                    default:
                        image_width_reg <= image_width_reg;
                endcase
                col_reg <= '0;
                row_reg <= '0;
                rc_reg  <= '0;
                bl_reg  <= '0;
            end
            else
            begin
                if (s_accept)
                begin
                    if (col_reg == col_last)
                    begin
                        col_reg <= '0;
                        if (row_reg == row_last)
                            row_reg <= '0;
                        else
                            row_reg <= row_reg + 1'b1;
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
                if (s1_adv)
                begin
                    rc_reg <= rc_next;
                    bl_reg <= bl_next;
                end
            end

            if (s_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // outputs
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b000_0000, white_reg};
    assign m_tlast  = frame_end_reg;

`ifndef NO_ASSERTIONS
    // column counter stays inside the line
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= col_last)
        else $error("column counter beyond last column");

    // line buffer writes stay inside the line
    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> wr_addr <= col_last)
        else $error("line buffer write beyond last column");

    // last pixel of a frame returns the counters to the frame origin
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && !cfg_we && col_reg == col_last && row_reg == row_last)
        |=> (col_reg == '0 && row_reg == '0))
        else $error("counters not cleared after last pixel");

    // right carry is dropped at the end of each line
    a_rc_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_last_col_reg && !cfg_we) |=> rc_reg == '0)
        else $error("right carry leaks across a line end");

    // a stalled output with a full stage blocks new input
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while both stages are blocked");
`endif

endmodule
